[rtl/core/eps_pkg.sv]
// shared constants and types for the exact pattern search block
package eps_pkg;

    localparam int          PATTERN_MAX_DEF = 32;
    localparam longint      TEXT_MAX_DEF    = 65536;
    localparam int          SYM_W           = 8;
    localparam int          POS_W           = 16;

    // request codes carried on req_type
    localparam logic        REQ_PATTERN     = 1'b0;
    localparam logic        REQ_TEXT        = 1'b1;

    // what one cell hands to its neighbor
    typedef struct packed {
        logic [SYM_W-1:0] text;
        logic [SYM_W-1:0] pat;
        logic             valid;
    } t_cell_link;

endpackage

[rtl/core/eps_cell.sv]
// one compare cell: a text byte, a pattern byte and a pattern valid bit
module eps_cell
    import eps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift_text,
    input  logic       i_shift_pat,
    input  t_cell_link i_link,
    output t_cell_link o_link,
    output logic       o_hit
);

    logic [SYM_W-1:0] r_text;
    logic [SYM_W-1:0] r_pat;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift_pat) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift_text) begin
            r_text <= i_link.text;
        end
        if (i_shift_pat) begin
            r_pat <= i_link.pat;
        end
    end

    assign o_link.text  = r_text;
    assign o_link.pat   = r_pat;
    assign o_link.valid = r_valid;

    // cells past the pattern end always agree
    assign o_hit = !r_valid || (r_text == r_pat);

endmodule

[rtl/core/exact_pattern_search.sv]
// top level of the exact pattern search: cell row, counters and output register
//
//  channel | signals                                   | direction
//  input   | i_in_valid / o_in_ready, req_type symbol first | in
//  output  | o_out_valid / i_out_ready, match_pos      | out
//
// one input transfer per cycle is taken; a text byte shifts the cell row and marks the
// check stage, which then resolves its compare into the output register
// the single check stage holds while the output register is full and stalled,
// and the input stalls behind it
// synchronous active-low reset clears counters, pattern valid bits and both stages
module exact_pattern_search
    import eps_pkg::*;
#(
    parameter int     PATTERN_MAX = PATTERN_MAX_DEF,
    parameter longint TEXT_MAX    = TEXT_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_first,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_match_pos
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = $clog2(TEXT_MAX + 1);
    localparam int XW = (LW > CW) ? LW : CW;

    logic [LW-1:0]    r_pat_len;
    logic [CW-1:0]    r_text_cnt;
    logic             r_chk;
    logic [POS_W-1:0] r_chk_pos;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;

    logic             in_fire;
    logic             is_pat;
    logic             pat_shift;
    logic             text_shift;
    logic [CW-1:0]    eff_cnt;
    logic [CW-1:0]    n_text_cnt;
    logic             chk;
    logic [POS_W-1:0] chk_pos;
    logic             adv;
    logic             match;

    t_cell_link       link_in  [PATTERN_MAX];
    t_cell_link       link_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hits;

    assign in_fire    = i_in_valid && o_in_ready;
    assign is_pat     = (i_req_type == REQ_PATTERN);
    assign pat_shift  = in_fire && is_pat
                        && (i_first || (r_pat_len != LW'(PATTERN_MAX)));
    assign eff_cnt    = i_first ? '0 : r_text_cnt;
    assign text_shift = in_fire && !is_pat && (eff_cnt != CW'(TEXT_MAX));
    assign n_text_cnt = eff_cnt + CW'(1);
    assign chk        = text_shift && (r_pat_len != '0)
                        && (XW'(n_text_cnt) >= XW'(r_pat_len));
    assign chk_pos    = POS_W'(XW'(n_text_cnt) - XW'(r_pat_len));

    assign adv        = r_chk && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_chk || adv;

    // newest bytes enter at cell 0, so cell k pairs text and pattern k bytes from the end
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign link_in[k].text  = i_symbol;
                assign link_in[k].pat   = i_symbol;
                assign link_in[k].valid = 1'b1;
            end else begin : g_body
                assign link_in[k].text  = link_out[k-1].text;
                assign link_in[k].pat   = link_out[k-1].pat;
                assign link_in[k].valid = link_out[k-1].valid && !i_first;
            end

            eps_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift_text (text_shift),
                .i_shift_pat  (pat_shift),
                .i_link       (link_in[k]),
                .o_link       (link_out[k]),
                .o_hit        (hits[k])
            );
        end
    endgenerate

    assign match = &hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= '0;
            r_text_cnt  <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pat_shift) begin
                r_pat_len <= i_first ? LW'(1) : r_pat_len + LW'(1);
            end
            if (text_shift) begin
                r_text_cnt <= n_text_cnt;
            end
            r_chk <= in_fire ? chk : (r_chk && !adv);
            if (adv && match) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_chk_pos <= chk_pos;
        end
        if (adv && match) begin
            r_out_pos <= r_chk_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_match_pos = r_out_pos;

endmodule
